// ----- rtl/core/websocket_frame_parser_defines.svh -----
// assertion macros shared by the frame parser
`ifndef WEBSOCKET_FRAME_PARSER_DEFINES_SVH
`define WEBSOCKET_FRAME_PARSER_DEFINES_SVH

// same-cycle implication, checked on every edge out of reset
`define WSFP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("websocket frame parser assertion failed");

// next-cycle implication, checked on every edge out of reset
`define WSFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("websocket frame parser assertion failed");

`endif

// ----- rtl/core/wsfp_pkg.sv -----
`default_nettype none

package wsfp_pkg;

    // width of the payload byte counter
    localparam int COUNT_BITS = 32;
    // largest length the counter can count
    localparam logic [63:0] COUNT_MAX = 64'((65'd1 << COUNT_BITS) - 65'd1);

    localparam logic [31:0] MAX_LEN_RESET = 32'd33554432;

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CLOSED  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        EV_BYTE  = 2'd0,
        EV_EMPTY = 2'd1,
        EV_CLOSE = 2'd2,
        EV_LONG  = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic        valid;
        event_kind_t kind;
        logic [7:0]  data;
        logic        last;
    } event_t;

endpackage

`default_nettype wire

// ----- rtl/core/wsfp_parser.sv -----
`default_nettype none

module wsfp_parser
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       rx_byte,
    input  wire logic [31:0]      max_frame_len,
    output wsfp_pkg::event_t      ev,
    output wsfp_pkg::phase_t      phase
);

    wsfp_pkg::phase_t                  phase_reg, phase_next;
    logic [3:0]                        opcode_reg, opcode_next;
    logic                              mask_reg, mask_next;
    logic [63:0]                       len_reg, len_next;
    logic [2:0]                        left_reg, left_next;
    logic [31:0]                       key_reg, key_next;
    logic [wsfp_pkg::COUNT_BITS-1:0]   count_reg, count_next;

    logic                              after_len;
    logic                              hdr_done;
    logic                              too_long;
    logic                              last_byte;
    logic [wsfp_pkg::COUNT_BITS:0]     count_inc;
    logic [1:0]                        key_sel;
    logic [7:0]                        key_byte;
    logic [7:0]                        plain_byte;

    assign count_inc  = {1'b0, count_reg} + {{wsfp_pkg::COUNT_BITS{1'b0}}, 1'b1};
    assign last_byte  = count_inc >= {1'b0, len_reg[wsfp_pkg::COUNT_BITS-1:0]};
    // first key byte sits in the top bits
    assign key_sel    = 2'd3 - count_reg[1:0];
    assign key_byte   = key_reg[{key_sel, 3'b000} +: 8];
    assign plain_byte = mask_reg ? (rx_byte ^ key_byte) : rx_byte;

    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        len_next    = len_reg;
        left_next   = left_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        after_len   = 1'b0;
        hdr_done    = 1'b0;
        ev          = '0;

        case (phase_reg)
            wsfp_pkg::PH_HDR0:
            begin
                opcode_next = rx_byte[3:0];
                phase_next  = wsfp_pkg::PH_HDR1;
            end
            wsfp_pkg::PH_HDR1:
            begin
                mask_next = rx_byte[7];
                len_next  = 64'd0;
                if (rx_byte[6:0] == wsfp_pkg::LEN_CODE_16)
                begin
                    left_next  = 3'd1;
                    phase_next = wsfp_pkg::PH_EXTLEN;
                end
                else if (rx_byte[6:0] == wsfp_pkg::LEN_CODE_64)
                begin
                    left_next  = 3'd7;
                    phase_next = wsfp_pkg::PH_EXTLEN;
                end
                else
                begin
                    len_next  = {57'd0, rx_byte[6:0]};
                    after_len = 1'b1;
                end
            end
            wsfp_pkg::PH_EXTLEN:
            begin
                len_next = {len_reg[55:0], rx_byte};
                if (left_reg != 3'd0)
                    left_next = left_reg - 3'd1;
                else
                    after_len = 1'b1;
            end
            wsfp_pkg::PH_MASK:
            begin
                key_next = {key_reg[23:0], rx_byte};
                if (left_reg != 3'd0)
                    left_next = left_reg - 3'd1;
                else
                    hdr_done = 1'b1;
            end
            wsfp_pkg::PH_PAYLOAD:
            begin
                count_next = count_inc[wsfp_pkg::COUNT_BITS-1:0];
                if (!last_byte)
                begin
                    if (opcode_reg == wsfp_pkg::OP_TEXT)
                    begin
                        ev.valid = accept;
                        ev.kind  = wsfp_pkg::EV_BYTE;
                        ev.data  = plain_byte;
                    end
                end
                else if (opcode_reg == wsfp_pkg::OP_CLOSE)
                begin
                    phase_next = wsfp_pkg::PH_CLOSED;
                    ev.valid   = accept;
                    ev.kind    = wsfp_pkg::EV_CLOSE;
                end
                else
                begin
                    phase_next = wsfp_pkg::PH_HDR0;
                    if (opcode_reg == wsfp_pkg::OP_TEXT)
                    begin
                        ev.valid = accept;
                        ev.kind  = wsfp_pkg::EV_BYTE;
                        ev.data  = plain_byte;
                        ev.last  = 1'b1;
                    end
                end
            end
            wsfp_pkg::PH_CLOSED:
            begin
                phase_next = wsfp_pkg::PH_CLOSED;
            end
            default:
            begin
                phase_next = wsfp_pkg::PH_CLOSED;
            end
        endcase

        // length field complete: either a mask key follows or the header is done
        if (after_len)
        begin
            if (mask_next)
            begin
                key_next   = 32'd0;
                left_next  = 3'd3;
                phase_next = wsfp_pkg::PH_MASK;
            end
            else
                hdr_done = 1'b1;
        end

        too_long = (len_next > {32'd0, max_frame_len}) || (len_next > wsfp_pkg::COUNT_MAX);

        // length check comes before the opcode is looked at
        if (hdr_done)
        begin
            if (too_long)
            begin
                phase_next = wsfp_pkg::PH_CLOSED;
                ev.valid   = accept;
                ev.kind    = wsfp_pkg::EV_LONG;
            end
            else
            begin
                count_next = '0;
                if (len_next != 64'd0)
                    phase_next = wsfp_pkg::PH_PAYLOAD;
                else if (opcode_next == wsfp_pkg::OP_CLOSE)
                begin
                    phase_next = wsfp_pkg::PH_CLOSED;
                    ev.valid   = accept;
                    ev.kind    = wsfp_pkg::EV_CLOSE;
                end
                else
                begin
                    phase_next = wsfp_pkg::PH_HDR0;
                    if (opcode_next == wsfp_pkg::OP_TEXT)
                    begin
                        ev.valid = accept;
                        ev.kind  = wsfp_pkg::EV_EMPTY;
                        ev.last  = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wsfp_pkg::PH_HDR0;
            opcode_reg <= 4'd0;
            mask_reg   <= 1'b0;
            len_reg    <= 64'd0;
            left_reg   <= 3'd0;
            key_reg    <= 32'd0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            len_reg    <= len_next;
            left_reg   <= left_next;
            key_reg    <= key_next;
            count_reg  <= count_next;
        end
    end

    assign phase = phase_reg;

endmodule

`default_nettype wire

// ----- rtl/core/wsfp_out_reg.sv -----
`default_nettype none

module wsfp_out_reg
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire wsfp_pkg::event_t ev,
    input  wire logic             m_axis_tready,
    output logic                  m_axis_tvalid,
    output logic [7:0]            m_axis_tdata,
    output logic [1:0]            m_axis_tuser,
    output logic                  m_axis_tlast,
    output logic                  free
);

    logic                  valid_reg, valid_next;
    wsfp_pkg::event_kind_t kind_reg;
    logic [7:0]            data_reg;
    logic                  last_reg;

    // slot can take a new result this cycle
    assign free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (ev.valid)
            valid_next = 1'b1;
        else if (m_axis_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ev.valid)
        begin
            kind_reg <= ev.kind;
            data_reg <= ev.data;
            last_reg <= ev.last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/websocket_frame_parser.sv -----
// websocket receive deframer: takes the stream one byte per transaction and
// parses each frame header (opcode, mask bit, 7/16/64-bit length, optional
// 4-byte mask key), then hands out the unmasked payload of text frames one
// byte per transaction with tlast on the last byte; an empty text frame gives
// one "empty message" result, other opcodes are swallowed, and a consumed
// close frame or a length above max_frame_len (or beyond the payload counter)
// gives one report, after which all bytes are dropped until reset. a byte is
// taken while s_axis_tready is high; the state update is combinational logic
// before one output register, so throughput is one byte per clock unless the
// output stalls; a result is on the master side in the cycle after its byte.
// s_axis_tready drops only while a result waits in the output register and
// m_axis_tready is low. the user must write max_frame_len (cfg_wr_en/cfg_wr_data)
// only while the block is idle, not enforced here; it takes effect at the next length check.
`default_nettype none
`include "websocket_frame_parser_defines.svh"

module websocket_frame_parser
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // receive stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] payload_byte
    output logic [1:0]       m_axis_tuser,   // [1:0] event_kind
    output logic             m_axis_tlast,   // message_end
    // configuration: max_frame_len
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data
);

    logic [31:0]       max_len_reg;
    logic              accept;
    logic              out_free;
    wsfp_pkg::event_t  ev;
    wsfp_pkg::phase_t  phase;

    // length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= wsfp_pkg::MAX_LEN_RESET;
        else if (cfg_wr_en)
            max_len_reg <= cfg_wr_data;
    end

    // a byte goes in whenever the output slot is empty or being drained
    assign s_axis_tready = out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // header and payload state machine
    wsfp_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .rx_byte       (s_axis_tdata),
        .max_frame_len (max_len_reg),
        .ev            (ev),
        .phase         (phase)
    );

    // result register
    wsfp_out_reg u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ev            (ev),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .free          (out_free)
    )
    ;

    // a closed stream never produces a result
    `WSFP_ASSERT_IMPL(a_closed_silent, phase == wsfp_pkg::PH_CLOSED, !ev.valid)
    // a report closes the stream for good
    `WSFP_ASSERT_NEXT(a_report_closes, ev.valid && (ev.kind == wsfp_pkg::EV_CLOSE || ev.kind == wsfp_pkg::EV_LONG), phase == wsfp_pkg::PH_CLOSED)
    // a new result never overwrites one still waiting
    `WSFP_ASSERT_IMPL(a_no_overwrite, ev.valid, out_free)
    // an empty message always ends a message
    `WSFP_ASSERT_IMPL(a_empty_ends, ev.valid && ev.kind == wsfp_pkg::EV_EMPTY, ev.last)

endmodule

`default_nettype wire

// ----- sim/websocket_frame_parser_test.sv -----
`timescale 1ns / 1ps

module websocket_frame_parser_test;

    // opcodes that the parser swallows, beside text and close from the package
    localparam logic [3:0] OPC_CONT     = 4'h0;
    localparam logic [3:0] OPC_BINARY   = 4'h2;
    localparam logic [3:0] OPC_PING     = 4'h9;
    localparam logic [3:0] OPC_PONG     = 4'hA;
    localparam logic [3:0] OPC_RESERVED = 4'hF;

    // cycles without any transaction before the run is declared hung
    localparam int STALL_LIMIT = 2000;

    // how the payload length is carried in the header
    typedef enum {FORM_SHORT, FORM_16, FORM_64} len_form_t;

    // the one report that ends the stream; only one can happen per run
    typedef enum {
        END_CLOSE_DATA,
        END_CLOSE_EMPTY,
        END_TOO_LONG,
        END_CLOSE_TOO_LONG,
        END_HUGE_LENGTH
    } stream_end_t;

    typedef struct packed {
        wsfp_pkg::event_kind_t kind;
        logic [7:0]            data;
        logic                  msg_end;
    } ws_event_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_wr_en     = 1'b0;
    logic [31:0] cfg_wr_data   = 32'd0;

    websocket_frame_parser dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [7:0] rx_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [7:0] payload_byte
        .m_axis_tuser  (m_axis_tuser),    // [1:0] event_kind
        .m_axis_tlast  (m_axis_tlast),    // message_end
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // deframer state as this bench tracks it, updated on every accepted byte
    // ---------------------------------------------------------------------
    wsfp_pkg::phase_t                rx_phase   = wsfp_pkg::PH_HDR0;
    logic [3:0]                      cur_opcode = 4'h0;
    logic                            masked     = 1'b0;
    logic [63:0]                     frame_len  = 64'd0;
    logic [2:0]                      bytes_left = 3'd0;
    logic [31:0]                     key        = 32'd0;
    logic [wsfp_pkg::COUNT_BITS-1:0] taken      = '0;
    logic [31:0]                     len_limit  = wsfp_pkg::MAX_LEN_RESET;

    // results still owed by the block, oldest first
    ws_event_t expected_events[$];

    // knobs and tallies
    int          sender_idle_pct = 0;
    int          recv_stall_pct  = 0;
    int          bytes_sent      = 0;
    int          frames_sent     = 0;
    int          text_frames     = 0;
    int          noise_bursts    = 0;
    int          limit_writes    = 0;
    int          results_checked = 0;
    int          mismatch_count  = 0;
    int          quiet_cycles    = 0;
    stream_end_t stream_end      = END_CLOSE_EMPTY;

    task automatic expect_event(input wsfp_pkg::event_kind_t kind, input logic [7:0] data,
                                input logic msg_end);
        ws_event_t ev;
        ev.kind    = kind;
        ev.data    = data;
        ev.msg_end = msg_end;
        expected_events.insert(expected_events.size(), ev);
    endtask

    // header and any mask key are in: length check first, then the opcode
    task automatic header_complete();
        if (frame_len > 64'(len_limit) || frame_len > wsfp_pkg::COUNT_MAX)
        begin
            rx_phase = wsfp_pkg::PH_CLOSED;
            expect_event(wsfp_pkg::EV_LONG, 8'h00, 1'b0);
        end
        else
        begin
            taken = '0;
            if (frame_len == 64'd0)
            begin
                rx_phase = wsfp_pkg::PH_HDR0;
                if (cur_opcode == wsfp_pkg::OP_CLOSE)
                begin
                    rx_phase = wsfp_pkg::PH_CLOSED;
                    expect_event(wsfp_pkg::EV_CLOSE, 8'h00, 1'b0);
                end
                else if (cur_opcode == wsfp_pkg::OP_TEXT)
                    expect_event(wsfp_pkg::EV_EMPTY, 8'h00, 1'b1);
            end
            else
                rx_phase = wsfp_pkg::PH_PAYLOAD;
        end
    endtask

    task automatic length_complete();
        if (masked)
        begin
            key        = 32'd0;
            bytes_left = 3'd3;
            rx_phase   = wsfp_pkg::PH_MASK;
        end
        else
            header_complete();
    endtask

    // advance the tracked state by one received byte and queue any result
    task automatic track_byte(input logic [7:0] b);
        logic [7:0] plain;
        logic       final_byte;
        case (rx_phase)
            wsfp_pkg::PH_HDR0:
            begin
                cur_opcode = b[3:0];
                rx_phase   = wsfp_pkg::PH_HDR1;
            end
            wsfp_pkg::PH_HDR1:
            begin
                masked    = b[7];
                frame_len = 64'd0;
                if (b[6:0] == wsfp_pkg::LEN_CODE_16)
                begin
                    bytes_left = 3'd1;
                    rx_phase   = wsfp_pkg::PH_EXTLEN;
                end
                else if (b[6:0] == wsfp_pkg::LEN_CODE_64)
                begin
                    bytes_left = 3'd7;
                    rx_phase   = wsfp_pkg::PH_EXTLEN;
                end
                else
                begin
                    frame_len = 64'(b[6:0]);
                    length_complete();
                end
            end
            wsfp_pkg::PH_EXTLEN:
            begin
                // extended length arrives big-endian
                frame_len = {frame_len[55:0], b};
                if (bytes_left != 3'd0)
                    bytes_left = bytes_left - 3'd1;
                else
                    length_complete();
            end
            wsfp_pkg::PH_MASK:
            begin
                // first key byte ends up in the top bits
                key = {key[23:0], b};
                if (bytes_left != 3'd0)
                    bytes_left = bytes_left - 3'd1;
                else
                    header_complete();
            end
            wsfp_pkg::PH_PAYLOAD:
            begin
                final_byte = (64'(taken) + 64'd1) >= frame_len;
                plain      = b;
                if (masked)
                    plain = b ^ key[(3 - taken[1:0]) * 8 +: 8];
                taken = taken + 1'b1;
                if (!final_byte)
                begin
                    if (cur_opcode == wsfp_pkg::OP_TEXT)
                        expect_event(wsfp_pkg::EV_BYTE, plain, 1'b0);
                end
                else
                begin
                    rx_phase = wsfp_pkg::PH_HDR0;
                    if (cur_opcode == wsfp_pkg::OP_CLOSE)
                    begin
                        rx_phase = wsfp_pkg::PH_CLOSED;
                        expect_event(wsfp_pkg::EV_CLOSE, 8'h00, 1'b0);
                    end
                    else if (cur_opcode == wsfp_pkg::OP_TEXT)
                        expect_event(wsfp_pkg::EV_BYTE, plain, 1'b1);
                end
            end
            default:
                rx_phase = wsfp_pkg::PH_CLOSED;
        endcase
    endtask

    // ---------------------------------------------------------------------
    // stimulus side
    // ---------------------------------------------------------------------

    // one byte over the receive stream, with random idle cycles in front
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        track_byte(b);
        bytes_sent++;
    endtask

    // hold off the sender until every owed result is out, then let the
    // output register settle
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        len_limit = value;
        limit_writes++;
    endtask

    function automatic len_form_t pick_form(input logic [63:0] len);
        int r;
        if (len <= 64'd125)
            r = $urandom_range(0, 2);
        else if (len <= 64'd65535)
            r = $urandom_range(1, 2);
        else
            r = 2;
        case (r)
            0:       return FORM_SHORT;
            1:       return FORM_16;
            default: return FORM_64;
        endcase
    endfunction

    // fin and rsv bits are random, the parser must not care
    task automatic send_header(input logic [3:0] opcode, input logic [63:0] len,
                               input logic use_mask, input len_form_t form);
        send_byte({4'($urandom_range(0, 15)), opcode});
        case (form)
            FORM_SHORT:
                send_byte({use_mask, len[6:0]});
            FORM_16:
            begin
                send_byte({use_mask, wsfp_pkg::LEN_CODE_16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default:
            begin
                send_byte({use_mask, wsfp_pkg::LEN_CODE_64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8 * i +: 8]);
            end
        endcase
        if (use_mask)
            repeat (4) send_byte(8'($urandom));
        frames_sent++;
        if (opcode == wsfp_pkg::OP_TEXT)
            text_frames++;
    endtask

    task automatic send_frame(input logic [3:0] opcode, input logic [63:0] len,
                              input logic use_mask, input len_form_t form);
        send_header(opcode, len, use_mask, form);
        repeat (int'(len)) send_byte(8'($urandom));
    endtask

    // bend a random byte so that the stream stays open: no close opcode and
    // no length above the current limit (capped at 255 to keep frames short)
    function automatic logic [7:0] tame_byte(input logic [7:0] b);
        int         cap;
        logic [7:0] t;
        cap = (len_limit < 32'd255) ? int'(len_limit) : 255;
        t   = b;
        case (rx_phase)
            wsfp_pkg::PH_HDR0:
                if (t[3:0] == wsfp_pkg::OP_CLOSE)
                    t[3:0] = wsfp_pkg::OP_TEXT;
            wsfp_pkg::PH_HDR1:
                if (t[6:0] < wsfp_pkg::LEN_CODE_16 && int'(t[6:0]) > cap)
                    t[6:0] = 7'(int'(t[6:0]) % (cap + 1));
            wsfp_pkg::PH_EXTLEN:
                t = (bytes_left != 3'd0) ? 8'h00 : 8'(int'(b) % (cap + 1));
            default:
                ;
        endcase
        return t;
    endfunction

    // a short burst of junk that breaks frame alignment, then filler until
    // the parser is back at a frame boundary
    task automatic send_noise();
        repeat ($urandom_range(1, 6)) send_byte(tame_byte(8'($urandom)));
        while (rx_phase != wsfp_pkg::PH_HDR0)
            send_byte(tame_byte(8'($urandom)));
        noise_bursts++;
    endtask

    task automatic send_random_frame();
        logic [3:0]  opcode;
        logic [63:0] len;
        int          cap;
        int          r;
        cap = (len_limit < 32'd255) ? int'(len_limit) : 255;
        if ($urandom_range(0, 1))
            opcode = wsfp_pkg::OP_TEXT;
        else
        begin
            opcode = 4'($urandom);
            if (opcode == wsfp_pkg::OP_CLOSE)
                opcode = OPC_PING;
        end
        // mostly short frames, sometimes up to the cap or exactly on it, else empty
        r = $urandom_range(0, 9);
        if (r < 6)
            len = $urandom_range(0, (cap < 12) ? cap : 12);
        else if (r < 8)
            len = $urandom_range(0, cap);
        else if (r == 8)
            len = cap;
        else
            len = 0;
        send_frame(opcode, len, 1'($urandom), pick_form(len));
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // every length form, masked and not, empty text and swallowed opcodes
    task automatic test_directed_frames();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        send_frame(wsfp_pkg::OP_TEXT, 0, 1'b0, FORM_SHORT);       // empty message
        send_frame(wsfp_pkg::OP_TEXT, 0, 1'b1, FORM_16);          // empty, key still read
        send_frame(wsfp_pkg::OP_TEXT, 1, 1'b0, FORM_SHORT);
        send_frame(wsfp_pkg::OP_TEXT, 6, 1'b1, FORM_64);          // key wraps round
        send_frame(wsfp_pkg::OP_TEXT, 125, 1'b1, FORM_SHORT);     // longest short form
        send_frame(OPC_BINARY, 3, 1'b1, FORM_SHORT);
        send_frame(OPC_PING, 0, 1'b0, FORM_SHORT);                // empty, no result
        send_frame(OPC_PONG, 2, 1'b0, FORM_16);
        send_frame(OPC_CONT, 2, 1'b1, FORM_SHORT);
        send_frame(OPC_RESERVED, 1, 1'b0, FORM_64);               // reserved, not checked
        send_frame(wsfp_pkg::OP_TEXT, 2, 1'b0, FORM_16);
        wait_drained();
    endtask

    // limit at zero, at all ones, and a frame sitting exactly on the limit
    task automatic test_limit_extremes();
        logic [31:0] lim;
        sender_idle_pct = 31;
        recv_stall_pct  = 31;
        write_limit(32'd0);
        send_frame(wsfp_pkg::OP_TEXT, 0, 1'b1, FORM_64);
        send_frame(OPC_BINARY, 0, 1'b0, FORM_16);
        send_frame(wsfp_pkg::OP_TEXT, 0, 1'b0, FORM_SHORT);
        send_noise();
        write_limit(32'hFFFF_FFFF);
        send_frame(wsfp_pkg::OP_TEXT, 40, 1'b1, FORM_16);
        lim = $urandom_range(1, 20);
        write_limit(lim);
        send_frame(wsfp_pkg::OP_TEXT, lim, 1'b1, pick_form(lim));
        write_limit(wsfp_pkg::MAX_LEN_RESET);
    endtask

    // bulk traffic under each idling pattern, a fresh limit for each
    task automatic test_random_traffic();
        int          stop_at;
        logic [31:0] lim;
        for (int p = 0; p < 4; p++)
        begin
            case ($urandom_range(0, 4))
                0:       lim = 32'hFFFF_FFFF;
                1:       lim = wsfp_pkg::MAX_LEN_RESET;
                2:       lim = $urandom;
                3:       lim = $urandom_range(1, 40);
                default: lim = 32'd0;
            endcase
            write_limit(lim);
            case (p)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 63; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin sender_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            stop_at = bytes_sent + 40;
            while (bytes_sent < stop_at)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_random_frame();
                else
                    send_noise();
            end
            // sender holds off until everything owed has come out
            wait_drained();
        end
    endtask

    // one way of closing the stream, then bytes that must be dropped
    task automatic test_stream_close();
        logic [63:0] len;
        logic [31:0] lim;
        sender_idle_pct = 31;
        recv_stall_pct  = 31;
        // a close frame with payload must not trip the length check
        write_limit(wsfp_pkg::MAX_LEN_RESET);
        stream_end = stream_end_t'($urandom_range(0, 4));
        case (stream_end)
            END_CLOSE_DATA:
            begin
                len = $urandom_range(1, 6);
                send_frame(wsfp_pkg::OP_CLOSE, len, 1'($urandom), pick_form(len));
            end
            END_CLOSE_EMPTY:
                send_frame(wsfp_pkg::OP_CLOSE, 0, 1'($urandom), pick_form(0));
            END_TOO_LONG, END_CLOSE_TOO_LONG:
            begin
                // one past the limit; a close frame reports too long as well
                lim = $urandom_range(0, 30);
                write_limit(lim);
                len = 64'(lim) + 64'd1;
                send_header((stream_end == END_CLOSE_TOO_LONG) ?
                            wsfp_pkg::OP_CLOSE : wsfp_pkg::OP_TEXT,
                            len, 1'($urandom), pick_form(len));
            end
            default:
            begin
                // beyond what the payload counter can count
                write_limit(32'hFFFF_FFFF);
                len = {$urandom, $urandom};
                len[32 + $urandom_range(0, 31)] = 1'b1;
                send_header(wsfp_pkg::OP_TEXT, len, 1'($urandom), FORM_64);
            end
        endcase
        repeat (20) send_byte(8'($urandom));
        wait_drained();
    endtask

    // ---------------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------------

    // random back-pressure on the result stream
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic report_mismatch(input string why, input ws_event_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s): expected kind %0d data %02h end %0d, %s %0d %s %02h %s %0d",
                     why, want.kind, want.data, want.msg_end,
                     "got kind", m_axis_tuser, "data", m_axis_tdata,
                     "end", m_axis_tlast);
    endtask

    // each result transaction against the oldest owed result
    always @(posedge clk)
    begin
        ws_event_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_checked++;
            if (expected_events.size() == 0)
            begin
                want = '0;
                report_mismatch("nothing expected", want);
            end
            else
            begin
                want = expected_events.pop_front();
                if (m_axis_tuser !== want.kind || m_axis_tdata !== want.data ||
                    m_axis_tlast !== want.msg_end)
                    report_mismatch("wrong field", want);
            end
        end
    end

    // watchdog: any transaction on either side restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results still owed",
                     quiet_cycles, expected_events.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_frames();
        test_limit_extremes();
        test_random_traffic();
        test_stream_close();
        repeat (10) @(posedge clk);
        $display("run: %0d bytes in %0d frames (%0d text), %0d noise bursts, %0d limit writes",
                 bytes_sent, frames_sent, text_frames, noise_bursts, limit_writes);
        $display("run: %0d results checked, %0d mismatches, stream ended by %s",
                 results_checked, mismatch_count, stream_end.name());
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- websocket_frame_parser.f -----
+incdir+rtl/core
rtl/core/wsfp_pkg.sv
rtl/core/wsfp_parser.sv
rtl/core/wsfp_out_reg.sv
rtl/core/websocket_frame_parser.sv
sim/websocket_frame_parser_test.sv
